[hw/rtl/dcc_pkg.sv]
// dcc_pkg: shared types, sizes and codes of the distinct colour counter
// used by dcc_table, dcc_ctrl and distinct_color_counter; no dependencies
`default_nettype none

package dcc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = IDX_W + 1;
    localparam int CH_W        = 8;
    localparam int KEY_W       = 3 * CH_W;
    localparam int CNT_W       = 19;
    localparam int ST_W        = 3;

    localparam longint IMAGE_SIDE      = 512;
    localparam longint SIDE_SQ         = IMAGE_SIDE * IMAGE_SIDE;
    localparam longint COUNT_FIELD_MAX = (longint'(1) << CNT_W) - 1;
    localparam logic [CNT_W-1:0] COUNT_MAX =
        CNT_W'((SIDE_SQ > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : SIDE_SQ);

    localparam logic [CH_W-1:0] DARK_RESET   = 8'd5;
    localparam logic [CH_W-1:0] BRIGHT_RESET = 8'd250;

    // configuration register indexes
    localparam logic CFG_DARK   = 1'b0;
    localparam logic CFG_BRIGHT = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_SKIPPED  = 3'd0,
        ST_MATCHED  = 3'd1,
        ST_INSERTED = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_READ     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic             we;
        logic             index;
        logic [CH_W-1:0]  data;
    } t_cfg_wr;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              key_we;
        logic              cnt_we;
        logic [IDX_W-1:0]  wr_addr;
        logic [KEY_W-1:0]  wr_key;
        logic [CNT_W-1:0]  wr_cnt;
    } t_mem_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  cnt;
    } t_mem_rsp;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  hit_index;
        logic [USED_W-1:0] distinct_colors;
        logic [CH_W-1:0]   read_red;
        logic [CH_W-1:0]   read_green;
        logic [CH_W-1:0]   read_blue;
        logic [CNT_W-1:0]  read_count;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/dcc_table.sv]
// dcc_table: colour key memory and count memory, one read and one write port each
// depends on dcc_pkg
`default_nettype none

module dcc_table (
    input  wire              i_clk,
    input  dcc_pkg::t_mem_req i_req,
    output dcc_pkg::t_mem_rsp o_rsp
);

    logic [dcc_pkg::KEY_W-1:0] key_mem [dcc_pkg::TABLE_DEPTH];
    logic [dcc_pkg::CNT_W-1:0] cnt_mem [dcc_pkg::TABLE_DEPTH];

    logic [dcc_pkg::KEY_W-1:0] r_key_q;
    logic [dcc_pkg::CNT_W-1:0] r_cnt_q;

    always_ff @(posedge i_clk) begin
        if (i_req.key_we) begin
            key_mem[i_req.wr_addr] <= i_req.wr_key;
        end
        if (i_req.rd_en) begin
            r_key_q <= key_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.cnt_we) begin
            cnt_mem[i_req.wr_addr] <= i_req.wr_cnt;
        end
        if (i_req.rd_en) begin
            r_cnt_q <= cnt_mem[i_req.rd_addr];
        end
    end

    assign o_rsp.key = r_key_q;
    assign o_rsp.cnt = r_cnt_q;

endmodule

`default_nettype wire

[hw/rtl/dcc_ctrl.sv]
// dcc_ctrl: sequencer for skip test, table scan, update and entry read
// holds limits, entry count and the pending result; depends on dcc_pkg
`default_nettype none

module dcc_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  dcc_pkg::t_cfg_wr             i_cfg,
    input  wire                          i_in_accept,
    input  wire                          i_cmd,
    input  wire [dcc_pkg::CH_W-1:0]      i_red,
    input  wire [dcc_pkg::CH_W-1:0]      i_green,
    input  wire [dcc_pkg::CH_W-1:0]      i_blue,
    input  wire [dcc_pkg::IDX_W-1:0]     i_entry_index,
    input  wire                          i_out_free,
    input  dcc_pkg::t_mem_rsp            i_rsp,
    output dcc_pkg::t_mem_req            o_req,
    output logic                         o_idle,
    output logic                         o_res_valid,
    output dcc_pkg::t_result             o_res
);

    dcc_pkg::t_state            r_state, n_state;
    logic [dcc_pkg::CH_W-1:0]   r_dark, r_bright;
    logic [dcc_pkg::USED_W-1:0] r_used, n_used;
    logic [dcc_pkg::KEY_W-1:0]  r_key, n_key;
    logic [dcc_pkg::USED_W-1:0] r_scan_addr, n_scan_addr;
    logic                       r_cmp_valid, n_cmp_valid;
    logic [dcc_pkg::IDX_W-1:0]  r_cmp_addr, n_cmp_addr;
    dcc_pkg::t_result           r_res, n_res;

    logic dark, bright, scan_rd, match, last_cmp, full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dcc_pkg::S_IDLE;
            r_dark      <= dcc_pkg::DARK_RESET;
            r_bright    <= dcc_pkg::BRIGHT_RESET;
            r_used      <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cmp_valid <= n_cmp_valid;
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    dcc_pkg::CFG_DARK:   r_dark   <= i_cfg.data;
                    dcc_pkg::CFG_BRIGHT: r_bright <= i_cfg.data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_scan_addr <= n_scan_addr;
        r_cmp_addr  <= n_cmp_addr;
        r_res       <= n_res;
    end

    always_comb begin
        dark   = (i_red < r_dark) && (i_green < r_dark) && (i_blue < r_dark);
        bright = (i_red > r_bright) && (i_green > r_bright) && (i_blue > r_bright);
        full   = (r_used == dcc_pkg::USED_W'(dcc_pkg::TABLE_DEPTH));
        scan_rd  = (r_scan_addr < r_used);
        match    = r_cmp_valid && (i_rsp.key == r_key);
        last_cmp = r_cmp_valid
                   && ((dcc_pkg::USED_W'(r_cmp_addr) + dcc_pkg::USED_W'(1)) == r_used);

        n_state     = r_state;
        n_used      = r_used;
        n_key       = r_key;
        n_scan_addr = r_scan_addr;
        n_cmp_valid = 1'b0;
        n_cmp_addr  = r_cmp_addr;
        n_res       = r_res;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;

        o_req         = '0;
        o_req.rd_addr = r_scan_addr[dcc_pkg::IDX_W-1:0];
        o_req.wr_addr = r_used[dcc_pkg::IDX_W-1:0];
        o_req.wr_key  = r_key;
        o_req.wr_cnt  = dcc_pkg::CNT_W'(1);

        unique case (r_state)
            dcc_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_accept) begin
                    n_key = {i_red, i_green, i_blue};
                    n_res = '0;
                    n_res.distinct_colors = r_used;
                    if (i_cmd) begin
                        n_res.status = dcc_pkg::ST_READ;
                        if (dcc_pkg::USED_W'(i_entry_index) < r_used) begin
                            o_req.rd_en   = 1'b1;
                            o_req.rd_addr = i_entry_index;
                            n_state       = dcc_pkg::S_READ;
                        end else begin
                            n_state = dcc_pkg::S_FINISH;
                        end
                    end else if (dark || bright) begin
                        n_res.status = dcc_pkg::ST_SKIPPED;
                        n_state      = dcc_pkg::S_FINISH;
                    end else if (r_used == '0) begin
                        // empty table: first colour goes straight to entry zero
                        o_req.key_we  = 1'b1;
                        o_req.cnt_we  = 1'b1;
                        o_req.wr_key  = {i_red, i_green, i_blue};
                        n_used        = dcc_pkg::USED_W'(1);
                        n_res.status  = dcc_pkg::ST_INSERTED;
                        n_res.distinct_colors = dcc_pkg::USED_W'(1);
                        n_state       = dcc_pkg::S_FINISH;
                    end else begin
                        n_scan_addr = '0;
                        n_state     = dcc_pkg::S_SCAN;
                    end
                end
            end
            dcc_pkg::S_SCAN: begin
                // issue one address a cycle, compare the word read last cycle
                o_req.rd_en = scan_rd;
                n_cmp_valid = scan_rd;
                n_cmp_addr  = r_scan_addr[dcc_pkg::IDX_W-1:0];
                if (scan_rd) begin
                    n_scan_addr = r_scan_addr + dcc_pkg::USED_W'(1);
                end
                if (match) begin
                    o_req.rd_en     = 1'b0;
                    n_cmp_valid     = 1'b0;
                    o_req.cnt_we    = 1'b1;
                    o_req.wr_addr   = r_cmp_addr;
                    o_req.wr_cnt    = (i_rsp.cnt < dcc_pkg::COUNT_MAX)
                                      ? i_rsp.cnt + dcc_pkg::CNT_W'(1) : i_rsp.cnt;
                    n_res.status    = dcc_pkg::ST_MATCHED;
                    n_res.hit_index = r_cmp_addr;
                    n_state         = dcc_pkg::S_FINISH;
                end else if (last_cmp) begin
                    o_req.rd_en = 1'b0;
                    n_cmp_valid = 1'b0;
                    n_state     = dcc_pkg::S_FINISH;
                    if (full) begin
                        n_res.status = dcc_pkg::ST_DROPPED;
                    end else begin
                        o_req.key_we    = 1'b1;
                        o_req.cnt_we    = 1'b1;
                        n_used          = r_used + dcc_pkg::USED_W'(1);
                        n_res.status    = dcc_pkg::ST_INSERTED;
                        n_res.hit_index = r_used[dcc_pkg::IDX_W-1:0];
                        n_res.distinct_colors = r_used + dcc_pkg::USED_W'(1);
                    end
                end
            end
            dcc_pkg::S_READ: begin
                n_res.read_red   = i_rsp.key[3*dcc_pkg::CH_W-1:2*dcc_pkg::CH_W];
                n_res.read_green = i_rsp.key[2*dcc_pkg::CH_W-1:dcc_pkg::CH_W];
                n_res.read_blue  = i_rsp.key[dcc_pkg::CH_W-1:0];
                n_res.read_count = i_rsp.cnt;
                n_state          = dcc_pkg::S_FINISH;
            end
            dcc_pkg::S_FINISH: begin
                o_res_valid = 1'b1;
                if (i_out_free) begin
                    n_state = dcc_pkg::S_IDLE;
                end
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[hw/rtl/distinct_color_counter.sv]
// distinct_color_counter: top level, sequencer, colour table and output register
// depends on dcc_pkg, dcc_table and dcc_ctrl
`default_nettype none

// usage
//   input channel i_valid / o_stall carries one word: i_cmd selects a pixel count
//   (i_red, i_green, i_blue) or a read of entry i_entry_index
//   output channel o_valid / i_stall returns exactly one result word per input word
//   one word in flight at a time; o_stall is low only while the sequencer is idle
// states, from accept back to idle with the output free
//   skipped pixel, or read beyond the used entries: finish state only
//   read of a used entry: read state (one memory read), then finish state
//   counted pixel: scan state (straight to finish on an empty table), which reads one
//   stored colour per cycle from the key memory, compares it and stops at a match
//   or the last used entry; the result shows on o_valid in the cycle after finish
// stall
//   a result held by i_stall stays in the output register; the next word is still
//   taken and worked on, and its result waits in the sequencer until the register frees
// reset
//   synchronous, active low: entry count to zero, limits to 5 and 250, output empty;
//   no memory clearing pass, entries past the count are never read
// configuration
//   i_cfg_we writes i_cfg_data into register i_cfg_index (0 dark, 1 bright limit);
//   the user must write only while no word is in flight; the block does not enforce it

module distinct_color_counter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_cmd,
    input  wire  [7:0]  i_red,
    input  wire  [7:0]  i_green,
    input  wire  [7:0]  i_blue,
    input  wire  [9:0]  i_entry_index,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic [9:0]  o_hit_index,
    output logic [10:0] o_distinct_colors,
    output logic [7:0]  o_read_red,
    output logic [7:0]  o_read_green,
    output logic [7:0]  o_read_blue,
    output logic [18:0] o_read_count
);

    dcc_pkg::t_cfg_wr  cfg;
    dcc_pkg::t_mem_req mem_req;
    dcc_pkg::t_mem_rsp mem_rsp;
    dcc_pkg::t_result  res;
    dcc_pkg::t_result  r_out;
    logic              r_out_valid, n_out_valid;
    logic              idle, res_valid, out_free, in_accept, res_load;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    assign o_stall   = !idle;
    assign in_accept = i_valid && idle;

    // output register frees when empty or when its word leaves this edge
    assign out_free  = !r_out_valid || !i_stall;
    assign res_load  = res_valid && out_free;

    dcc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_accept   (in_accept),
        .i_cmd         (i_cmd),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_entry_index (i_entry_index),
        .i_out_free    (out_free),
        .i_rsp         (mem_rsp),
        .o_req         (mem_req),
        .o_idle        (idle),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    dcc_table u_table (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    always_comb begin
        if (res_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out.status;
    assign o_hit_index       = r_out.hit_index;
    assign o_distinct_colors = r_out.distinct_colors;
    assign o_read_red        = r_out.read_red;
    assign o_read_green      = r_out.read_green;
    assign o_read_blue       = r_out.read_blue;
    assign o_read_count      = r_out.read_count;

    // an accepted word keeps the input closed on the following cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted twice in a row");

    // a new entry always lands at the end of the table
    a_insert_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dcc_pkg::ST_INSERTED)
        |-> ({1'b0, o_hit_index} + 11'd1 == o_distinct_colors))
        else $error("inserted entry not at end of table");

    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distinct_colors <= 11'(dcc_pkg::TABLE_DEPTH)))
        else $error("entry count beyond table depth");

    // read fields are zero on every result that is not read data
    a_read_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != dcc_pkg::ST_READ)
        |-> (o_read_count == '0 && o_read_red == '0 && o_read_green == '0
             && o_read_blue == '0))
        else $error("read fields set on a pixel result");

endmodule

`default_nettype wire
